// ===== rtl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Types and constants shared by the single-wire bus master modules.
// ----------------------------------------------------------------------------
package owb_pkg;

  // input beat kinds (tuser)
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // configuration register indexes
  localparam int unsigned NUM_CFG = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ZERO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_REC      = 3'd6;

  localparam int unsigned US_W = 10;

  // fixed slot timing in microseconds
  localparam logic [US_W-1:0] RESET_PRE_US  = 10'd20;
  localparam logic [US_W-1:0] WRITE_ONE_LOW = 10'd1;
  localparam logic [US_W-1:0] WRITE_ONE_REL = 10'd120;
  localparam logic [US_W-1:0] WRITE_ZERO_REL = 10'd30;
  localparam logic [US_W-1:0] READ_LOW_US   = 10'd1;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_RPRE   = 11'b000_0000_0010,
    PH_RLOW   = 11'b000_0000_0100,
    PH_RWAIT  = 11'b000_0000_1000,
    PH_RREC   = 11'b000_0001_0000,
    PH_GAP    = 11'b000_0010_0000,
    PH_WLOW   = 11'b000_0100_0000,
    PH_WREL   = 11'b000_1000_0000,
    PH_RDLOW  = 11'b001_0000_0000,
    PH_RDWAIT = 11'b010_0000_0000,
    PH_RDREC  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [US_W-1:0] reset_low_us;
    logic [US_W-1:0] presence_sample_us;
    logic [US_W-1:0] reset_recovery_us;
    logic [US_W-1:0] byte_gap_us;
    logic [US_W-1:0] write_zero_low_us;
    logic [US_W-1:0] read_sample_us;
    logic [US_W-1:0] read_recovery_us;
  } cfg_t;

  typedef struct packed {
    phase_t          phase;
    logic [US_W-1:0] us_timer;
    logic [2:0]      bit_index;
    logic [7:0]      shift_reg;
    logic            presence;
    logic [1:0]      op_kind;
    logic [7:0]      rx_last;
  } eng_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       cmd_rejected;
  } res_t;

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

endpackage

// ===== rtl/owb_cfg.sv =====
// ----------------------------------------------------------------------------
// owb_cfg
// Timing register file; write-only, indexes past the last register ignored.
// ----------------------------------------------------------------------------
module owb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owb_pkg::US_W-1:0]      cfg_data,
  output owb_pkg::cfg_t                 cfg
);
  import owb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us       <= 10'd750;
      cfg.presence_sample_us <= 10'd70;
      cfg.reset_recovery_us  <= 10'd410;
      cfg.byte_gap_us        <= 10'd90;
      cfg.write_zero_low_us  <= 10'd90;
      cfg.read_sample_us     <= 10'd10;
      cfg.read_recovery_us   <= 10'd55;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:    cfg.reset_low_us       <= cfg_data;
        CFG_PRESENCE_SMP: cfg.presence_sample_us <= cfg_data;
        CFG_RESET_REC:    cfg.reset_recovery_us  <= cfg_data;
        CFG_BYTE_GAP:     cfg.byte_gap_us        <= cfg_data;
        CFG_WRITE_ZERO:   cfg.write_zero_low_us  <= cfg_data;
        CFG_READ_SMP:     cfg.read_sample_us     <= cfg_data;
        CFG_READ_REC:     cfg.read_recovery_us   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/owb_step.sv =====
// ----------------------------------------------------------------------------
// owb_step
// Next-state logic for one beat: tick or command, including the short chain
// of zero-length phases that are passed through within the same beat.
// ----------------------------------------------------------------------------
module owb_step (
  input  owb_pkg::eng_t eng,
  input  owb_pkg::cfg_t cfg,
  input  logic [1:0]    func,
  input  logic [7:0]    tx_byte,
  input  logic          line_in,
  output owb_pkg::eng_t eng_next,
  output owb_pkg::res_t res
);
  import owb_pkg::*;

  // longest chain: reset pre-phase ends with zero low, wait and recovery times
  localparam int unsigned CHAIN = 4;

  function automatic logic [US_W-1:0] phase_len(eng_t s, cfg_t c);
    logic [US_W-1:0] len;
    len = '0;
    case (s.phase)
      PH_RPRE:   len = RESET_PRE_US;
      PH_RLOW:   len = c.reset_low_us;
      PH_RWAIT:  len = c.presence_sample_us;
      PH_RREC:   len = c.reset_recovery_us;
      PH_GAP:    len = c.byte_gap_us;
      PH_WLOW:   len = s.shift_reg[0] ? WRITE_ONE_LOW : c.write_zero_low_us;
      PH_WREL:   len = s.shift_reg[0] ? WRITE_ONE_REL : WRITE_ZERO_REL;
      PH_RDLOW:  len = READ_LOW_US;
      PH_RDWAIT: len = c.read_sample_us;
      PH_RDREC:  len = c.read_recovery_us;
      default:   len = '0;
    endcase
    return len;
  endfunction

  // end-of-phase action; the returned phase is the one to enter next
  function automatic eng_t phase_end(eng_t s, logic line);
    eng_t r;
    r = s;
    case (s.phase)
      PH_RPRE:  r.phase = PH_RLOW;
      PH_RLOW:  r.phase = PH_RWAIT;
      PH_RWAIT: begin
        r.presence = ~line;
        r.phase    = PH_RREC;
      end
      PH_RREC:  r.phase = PH_IDLE;
      PH_GAP:   r.phase = (s.op_kind == FUNC_WRITE) ? PH_WLOW : PH_RDLOW;
      PH_WLOW:  r.phase = PH_WREL;
      PH_WREL: begin
        if (s.bit_index == LAST_BIT) begin
          r.phase = PH_IDLE;
        end else begin
          r.bit_index = s.bit_index + 3'd1;
          r.shift_reg = s.shift_reg >> 1;
          r.phase     = PH_WLOW;
        end
      end
      PH_RDLOW: r.phase = PH_RDWAIT;
      PH_RDWAIT: begin
        if (line) begin
          r.shift_reg[s.bit_index] = 1'b1;
        end
        r.phase = PH_RDREC;
      end
      PH_RDREC: begin
        if (s.bit_index == LAST_BIT) begin
          r.rx_last = s.shift_reg;
          r.phase   = PH_IDLE;
        end else begin
          r.bit_index = s.bit_index + 3'd1;
          r.phase     = PH_RDLOW;
        end
      end
      default:  r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  eng_t            s;
  logic            entering;
  logic            done;
  logic            rejected;
  logic [US_W-1:0] len;

  always_comb begin
    s        = eng;
    entering = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;
    len      = '0;

    if (func == FUNC_TICK) begin
      if (s.phase != PH_IDLE) begin
        if (s.us_timer != '0) begin
          s.us_timer = s.us_timer - 10'd1;
        end
        if (s.us_timer == '0) begin
          s        = phase_end(s, line_in);
          entering = 1'b1;
        end
      end
    end else if (s.phase != PH_IDLE) begin
      rejected = 1'b1;
    end else begin
      s.op_kind   = func;
      s.bit_index = '0;
      entering    = 1'b1;
      if (func == FUNC_RESET) begin
        s.phase = PH_RPRE;
      end else begin
        s.shift_reg = (func == FUNC_WRITE) ? tx_byte : 8'd0;
        s.phase     = PH_GAP;
      end
    end

    // pass through phases whose length is zero
    for (int k = 0; k < CHAIN; k++) begin
      if (entering) begin
        if (s.phase == PH_IDLE) begin
          s.us_timer = '0;
          done       = 1'b1;
          entering   = 1'b0;
        end else begin
          len        = phase_len(s, cfg);
          s.us_timer = len;
          if (len != '0) begin
            entering = 1'b0;
          end else begin
            s = phase_end(s, line_in);
          end
        end
      end
    end

    eng_next         = s;
    res.drive_low    = s.phase inside {PH_RLOW, PH_WLOW, PH_RDLOW};
    res.busy_res     = (s.phase != PH_IDLE);
    res.done_res     = done;
    res.presence     = s.presence;
    res.rx_byte      = s.rx_last;
    res.cmd_rejected = rejected;
  end

endmodule

// ===== rtl/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Single-wire bus master: reset/presence, byte write and byte read slots,
// timed by microsecond tick beats.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake            | payload
//  s_axis    | in  | tvalid/tready        | tuser: func[1:0]; tdata: tx_byte, line_in
//  m_axis    | out | tvalid/tready        | tdata: drive_low .. cmd_rejected
//  cfg       | in  | cfg_we (no back-off) | cfg_index, cfg_data
//
//  One beat in, one beat out; each accepted beat updates the state and
//  lands in the output register on the accepting edge.
//  A new beat is taken each cycle the output register is empty or drained.
//  rst (synchronous) returns to idle and restores default timing values.
//  A stalled output holds its beat and blocks input until taken.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] tx_byte, [8] line_in, [15:9] zero
  input  logic [owb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] rx_byte, [12] cmd_rejected, [15:13] zero
  output logic [owb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owb_pkg::US_W-1:0]      cfg_data
);
  import owb_pkg::*;

  cfg_t cfg;
  eng_t eng;
  eng_t eng_next;
  res_t res;
  logic s_fire;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  owb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owb_step u_step (
    .eng      (eng),
    .cfg      (cfg),
    .func     (s_axis_tuser),
    .tx_byte  (s_axis_tdata[7:0]),
    .line_in  (s_axis_tdata[8]),
    .eng_next (eng_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      eng.phase     <= PH_IDLE;
      eng.us_timer  <= '0;
      eng.bit_index <= '0;
      eng.shift_reg <= '0;
      eng.presence  <= 1'b0;
      eng.op_kind   <= '0;
      eng.rx_last   <= '0;
    end else if (s_fire) begin
      eng <= eng_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= {3'b000, res.cmd_rejected, res.rx_byte, res.presence,
                       res.done_res, res.busy_res, res.drive_low};
    end
  end

  // a command beat while busy comes back flagged and leaves the state alone
  a_reject: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tuser != FUNC_TICK && eng.phase != PH_IDLE
      |=> m_axis_tdata[12] && eng == $past(eng))
    else $error("busy command not rejected");

  // a tick while idle changes nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tuser == FUNC_TICK && eng.phase == PH_IDLE
      |=> eng == $past(eng))
    else $error("idle tick altered state");

  // every active phase has time left to run
  a_timer: assert property (@(posedge clk) disable iff (rst)
    eng.phase != PH_IDLE |-> eng.us_timer != '0)
    else $error("active phase with zero timer");

  // a completion beat reports the master idle and released
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
    else $error("done beat while busy");

  // state moves only on an accepted beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> eng == $past(eng))
    else $error("state changed without a beat");

endmodule

// ===== bench/tb_one_wire_bus_master_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_unit
// Self-checking bench for the single-wire bus master. A queue of command and
// tick beats feeds a stream driver. Each accepted beat runs through a local
// timing model of the reset, write and read slots. The monitor matches every
// output beat against that model's prediction. Timing registers are reloaded
// between phases while the bus is idle. The phases cover the defaults, all
// zero and random short settings. Both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_unit;
  import owb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 3;
  localparam int unsigned PHASE_BEATS    = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(NUM_CFG);

  typedef struct {
    logic [1:0] func;
    logic [7:0] tx;
    logic       line;
  } beat_t;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_RAND} line_drive_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = FUNC_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [US_W-1:0]      cfg_data = '0;

  one_wire_bus_master_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bus timing model state
  logic [US_W-1:0] cfg_val [NUM_CFG];
  logic [US_W-1:0] next_cfg [NUM_CFG];
  phase_t          slot;
  logic [US_W-1:0] slot_timer;
  logic [2:0]      bit_idx;
  logic [7:0]      shift_byte;
  logic            present;
  logic [1:0]      op_kind;
  logic [7:0]      rx_last;
  logic            done_pulse;

  beat_t  pending_beats[$];
  res_t   expected_res[$];
  beat_t  cur_beat;
  int unsigned gap_left, stall_left, quiet_cycles;
  bit     drv_calm, mon_calm;
  int unsigned queued, beats_checked, fail_count, settings_used;
  int unsigned resets_run, writes_run, reads_run, ops_finished, refusals;

  function automatic void model_reset();
    cfg_val[CFG_RESET_LOW]    = 10'd750;
    cfg_val[CFG_PRESENCE_SMP] = 10'd70;
    cfg_val[CFG_RESET_REC]    = 10'd410;
    cfg_val[CFG_BYTE_GAP]     = 10'd90;
    cfg_val[CFG_WRITE_ZERO]   = 10'd90;
    cfg_val[CFG_READ_SMP]     = 10'd10;
    cfg_val[CFG_READ_REC]     = 10'd55;
    slot = PH_IDLE;
    slot_timer = '0;
    bit_idx = '0;
    shift_byte = '0;
    present = 1'b0;
    op_kind = FUNC_TICK;
    rx_last = '0;
    done_pulse = 1'b0;
  endfunction

  function automatic logic [US_W-1:0] slot_len(phase_t p);
    case (p)
      PH_RPRE:   return RESET_PRE_US;
      PH_RLOW:   return cfg_val[CFG_RESET_LOW];
      PH_RWAIT:  return cfg_val[CFG_PRESENCE_SMP];
      PH_RREC:   return cfg_val[CFG_RESET_REC];
      PH_GAP:    return cfg_val[CFG_BYTE_GAP];
      PH_WLOW:   return shift_byte[0] ? WRITE_ONE_LOW : cfg_val[CFG_WRITE_ZERO];
      PH_WREL:   return shift_byte[0] ? WRITE_ONE_REL : WRITE_ZERO_REL;
      PH_RDLOW:  return READ_LOW_US;
      PH_RDWAIT: return cfg_val[CFG_READ_SMP];
      PH_RDREC:  return cfg_val[CFG_READ_REC];
      default:   return '0;
    endcase
  endfunction

  // work done as a slot runs out; returns the slot that follows
  function automatic phase_t end_slot(phase_t p, logic line);
    case (p)
      PH_RPRE:  return PH_RLOW;
      PH_RLOW:  return PH_RWAIT;
      PH_RWAIT: begin
        present = !line;
        return PH_RREC;
      end
      PH_RREC:  return PH_IDLE;
      PH_GAP:   return (op_kind == FUNC_WRITE) ? PH_WLOW : PH_RDLOW;
      PH_WLOW:  return PH_WREL;
      PH_WREL: begin
        if (bit_idx == LAST_BIT) return PH_IDLE;
        bit_idx = bit_idx + 3'd1;
        shift_byte = shift_byte >> 1;
        return PH_WLOW;
      end
      PH_RDLOW: return PH_RDWAIT;
      PH_RDWAIT: begin
        if (line) shift_byte[bit_idx] = 1'b1;
        return PH_RDREC;
      end
      PH_RDREC: begin
        if (bit_idx == LAST_BIT) begin
          rx_last = shift_byte;
          return PH_IDLE;
        end
        bit_idx = bit_idx + 3'd1;
        return PH_RDLOW;
      end
      default:  return PH_IDLE;
    endcase
  endfunction

  // zero-length slots fall through in the same beat
  function automatic void enter_slot(phase_t p, logic line);
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      slot = p;
      if (p == PH_IDLE) begin
        slot_timer = '0;
        done_pulse = 1'b1;
        ops_finished++;
        settled = 1'b1;
      end else begin
        slot_timer = slot_len(p);
        if (slot_timer != '0) settled = 1'b1;
        else p = end_slot(p, line);
      end
    end
  endfunction

  function automatic res_t bus_step(beat_t b);
    res_t r;
    logic refused;
    refused = 1'b0;
    done_pulse = 1'b0;
    if (b.func == FUNC_TICK) begin
      if (slot != PH_IDLE) begin
        if (slot_timer != '0) slot_timer = slot_timer - 10'd1;
        if (slot_timer == '0) enter_slot(end_slot(slot, b.line), b.line);
      end
    end else if (slot != PH_IDLE) begin
      refused = 1'b1;
      refusals++;
    end else begin
      op_kind = b.func;
      bit_idx = '0;
      if (b.func == FUNC_RESET) begin
        resets_run++;
        enter_slot(PH_RPRE, b.line);
      end else begin
        if (b.func == FUNC_WRITE) writes_run++;
        else reads_run++;
        shift_byte = (b.func == FUNC_WRITE) ? b.tx : 8'h00;
        enter_slot(PH_GAP, b.line);
      end
    end
    r.drive_low = (slot == PH_RLOW) || (slot == PH_WLOW) || (slot == PH_RDLOW);
    r.busy_res = (slot != PH_IDLE);
    r.done_res = done_pulse;
    r.presence = present;
    r.rx_byte = rx_last;
    r.cmd_rejected = refused;
    return r;
  endfunction

  // ticks a command needs under the current timing set
  function automatic int unsigned op_ticks(logic [1:0] f, logic [7:0] tx);
    int unsigned n;
    int i;
    n = 0;
    case (f)
      FUNC_RESET: n = RESET_PRE_US + cfg_val[CFG_RESET_LOW] + cfg_val[CFG_PRESENCE_SMP]
                      + cfg_val[CFG_RESET_REC];
      FUNC_WRITE: begin
        n = cfg_val[CFG_BYTE_GAP];
        for (i = 0; i < 8; i++)
          n = n + (tx[i] ? WRITE_ONE_LOW + WRITE_ONE_REL
                         : cfg_val[CFG_WRITE_ZERO] + WRITE_ZERO_REL);
      end
      FUNC_READ:  n = cfg_val[CFG_BYTE_GAP]
                      + 8 * (READ_LOW_US + cfg_val[CFG_READ_SMP] + cfg_val[CFG_READ_REC]);
      default:    n = 0;
    endcase
    return n;
  endfunction

  function automatic int unsigned pause_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic line_of(line_drive_t lm);
    case (lm)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1, 0));
    endcase
  endfunction

  function automatic logic [US_W-1:0] short_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 85) return US_W'($urandom_range(6, 1));
    return US_W'($urandom_range(60, 7));
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_res.push_back(bus_step(cur_beat));
      if (!s_axis_tvalid || s_axis_tready) begin
        if ($urandom_range(63) == 0) drv_calm = !drv_calm;
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tuser <= cur_beat.func;
          s_axis_tdata <= {7'd0, cur_beat.line, cur_beat.tx};
          s_axis_tvalid <= 1'b1;
          gap_left = pause_len(drv_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t got, want;
    int unsigned s;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive_low = m_axis_tdata[0];
        got.busy_res = m_axis_tdata[1];
        got.done_res = m_axis_tdata[2];
        got.presence = m_axis_tdata[3];
        got.rx_byte = m_axis_tdata[11:4];
        got.cmd_rejected = m_axis_tdata[12];
        if (expected_res.size() == 0) begin
          if (fail_count < 10)
            $display("beat %0d: result arrived with nothing pending (tdata %04h)",
                     beats_checked, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"beat %0d: drive_low %0b/%0b busy %0b/%0b done %0b/%0b ",
                        "presence %0b/%0b rx_byte %02h/%02h rejected %0b/%0b (exp/got)"},
                       beats_checked, want.drive_low, got.drive_low, want.busy_res,
                       got.busy_res, want.done_res, got.done_res, want.presence,
                       got.presence, want.rx_byte, got.rx_byte, want.cmd_rejected,
                       got.cmd_rejected);
            fail_count++;
          end
        end
        beats_checked++;
      end
      if ($urandom_range(63) == 0) mon_calm = !mon_calm;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        s = pause_len(mon_calm);
        m_axis_tready <= (s == 0);
        stall_left = (s == 0) ? 0 : s - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_one_wire_bus_master_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(logic [1:0] f, logic [7:0] tx, logic line, bit counted);
    beat_t b;
    b.func = f;
    b.tx = tx;
    b.line = line;
    pending_beats.push_back(b);
    if (counted) queued++;
  endtask

  // command followed by its ticks; busy commands sprinkled in, optionally cut short
  task automatic run_op(logic [1:0] f, logic [7:0] tx, line_drive_t lm,
                        int unsigned noise_pct, bit cut);
    int unsigned n, k;
    n = op_ticks(f, tx);
    if (cut && n > 1) n = $urandom_range(n - 1, 1);
    push_beat(f, tx, line_of(LINE_RAND), 1'b1);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < noise_pct)
        push_beat(2'($urandom_range(3, 1)), 8'($urandom), line_of(LINE_RAND), 1'b1);
      push_beat(FUNC_TICK, 8'($urandom), line_of(lm), 1'b1);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_res.size() != 0);
  endtask

  // finish any operation left running so registers change only while idle
  task automatic settle();
    drain();
    while (slot != PH_IDLE) begin
      push_beat(FUNC_TICK, 8'($urandom), line_of(LINE_RAND), 1'b1);
      drain();
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic load_setting(bit poke_unused);
    int i;
    for (i = 0; i < NUM_CFG; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= next_cfg[i];
      cfg_val[i] = next_cfg[i];
    end
    // writes past the last register must be dropped
    if (poke_unused) begin
      @(posedge clk);
      cfg_index <= CFG_UNUSED;
      cfg_data <= US_W'($urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int i, p, r;
    int unsigned start;
    logic [1:0] f;
    model_reset();
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // power-on timing: idle ticks, then one full read byte
    push_beat(FUNC_TICK, 8'h3C, 1'b0, 1'b0);
    push_beat(FUNC_TICK, 8'hC3, 1'b1, 1'b0);
    run_op(FUNC_READ, 8'h00, LINE_RAND, 0, 1'b0);
    settle();

    // every timing register zero: configurable phases collapse onto the beat that reaches them
    for (i = 0; i < NUM_CFG; i++) next_cfg[i] = '0;
    load_setting(1'b1);
    run_op(FUNC_RESET, 8'h00, LINE_LOW, 2, 1'b0);
    run_op(FUNC_WRITE, 8'h00, LINE_RAND, 0, 1'b0);
    run_op(FUNC_READ, 8'h00, LINE_HIGH, 0, 1'b0);
    run_op(FUNC_READ, 8'h00, LINE_LOW, 0, 1'b0);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      for (i = 0; i < NUM_CFG; i++) next_cfg[i] = short_time();
      load_setting(1'($urandom_range(1, 0)));
      start = queued;
      while (queued - start < PHASE_BEATS) begin
        r = $urandom_range(99);
        f = (r < 45) ? FUNC_RESET : (r < 90) ? FUNC_READ : FUNC_WRITE;
        run_op(f, 8'($urandom), LINE_RAND, 2, $urandom_range(9) == 0);
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(3, 1))
            push_beat(FUNC_TICK, 8'($urandom), line_of(LINE_RAND), 1'b0);
      end
      settle();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("checked %0d result beats over %0d timing sets", beats_checked, settings_used);
    $display("operations: %0d resets, %0d writes, %0d reads, %0d finished, %0d refused",
             resets_run, writes_run, reads_run, ops_finished, refusals);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("tb_one_wire_bus_master_unit: clean");
    end else begin
      $display("tb_one_wire_bus_master_unit: errors");
    end
    $finish;
  end

endmodule
